>>> rtl/dlwp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlwp_pkg
// Shared types and constants for the longest weighted path unit.
// ----------------------------------------------------------------------------
package dlwp_pkg;

  localparam int unsigned ScoreW     = 31;
  localparam int unsigned NodeIdxW   = 6;
  localparam int unsigned MaskW      = 64;
  localparam int unsigned NodeCountW = 7;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 7;

  localparam logic [ScoreW-1:0]     ScoreMax       = {ScoreW{1'b1}};
  localparam logic [NodeCountW-1:0] NodeCountReset = 7'd64;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgNodeCount = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDirection = 2'd1;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StDrain,
    StSum,
    StFinish
  } dlwp_state_e;

endpackage
`default_nettype wire

>>> rtl/dag_longest_weighted_path_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dag_longest_weighted_path_unit
// Longest node-weighted path over a topologically numbered graph, one node
// word at a time, with a score store scanned by one shared compare unit.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------------
//  input   | in_valid_i / in_ready_o| node_index, node_start, node_end,
//          |                        | neighbour_mask, first_node, last_node
//  output  | out_valid_o/out_ready_i| path_length, saturated
//  config  | cfg_we_i (no wait)     | cfg_index_i, cfg_data_i
//
//  A run-start word passes through accept and sum only. Any other word is
//  accepted, then scans all MAX_NODES entries, reading and comparing one
//  stored score per cycle, then takes one drain and one sum step. A last
//  word then enters a finish step that loads the output register, and holds
//  there while that register is still full. Reset marks every store entry as
//  zero through per-entry valid bits; no clearing pass is needed. in_ready_o
//  is high only when the sequencer is idle.
// ----------------------------------------------------------------------------
module dag_longest_weighted_path_unit #(
  parameter int unsigned MAX_NODES = 64
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration
  input  wire logic                               cfg_we_i,
  input  wire logic [dlwp_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [dlwp_pkg::CfgDataW-1:0]      cfg_data_i,
  // input words
  input  wire logic                               in_valid_i,
  output      logic                               in_ready_o,
  input  wire logic [dlwp_pkg::NodeIdxW-1:0]      node_index_i,
  input  wire logic [dlwp_pkg::ScoreW-1:0]        node_start_i,
  input  wire logic [dlwp_pkg::ScoreW-1:0]        node_end_i,
  input  wire logic [dlwp_pkg::MaskW-1:0]         neighbour_mask_i,
  input  wire logic                               first_node_i,
  input  wire logic                               last_node_i,
  // result words
  output      logic                               out_valid_o,
  input  wire logic                               out_ready_i,
  output      logic [dlwp_pkg::ScoreW-1:0]        path_length_o,
  output      logic                               saturated_o
);

  localparam int unsigned AW = $clog2(MAX_NODES);
  localparam logic [AW-1:0] LastEntry = AW'(MAX_NODES - 1);
  localparam int unsigned SW = dlwp_pkg::ScoreW;

  // state
  dlwp_pkg::dlwp_state_e state_q, state_d;

  // configuration; direction only states the order of presentation and has
  // no effect on the score rule, so it is decoded and dropped
  logic [dlwp_pkg::NodeCountW-1:0] node_count_q;

  // latched word
  logic [dlwp_pkg::NodeIdxW-1:0] idx_q;
  logic [MAX_NODES-1:0]          mask_q;
  logic                          last_q;
  logic [SW:0]                   len_q;   // up to 2^31

  // score store and its valid bits (invalid entry reads as zero)
  logic [SW-1:0]        mem_q [MAX_NODES];
  logic [MAX_NODES-1:0] valid_q;
  logic [SW-1:0]        rd_data_q;
  logic                 cmp_vld_q;

  // scan counter and running maximum
  logic [AW-1:0] cnt_q;
  logic [SW-1:0] best_q;
  logic          sat_seen_q;

  // output register
  logic          out_valid_q;
  logic [SW-1:0] out_len_q;
  logic          out_sat_q;

  // control
  logic in_accept;
  logic out_load;
  logic store_en;
  logic idx_in_range;

  // length of the presented node
  logic [dlwp_pkg::NodeCountW-1:0] last_virt;
  logic                            len_zero;
  logic [SW:0]                     len_d;

  // sum and clip
  logic [SW+1:0] sum_w;
  logic          sum_sat;
  logic [SW-1:0] sum_clip;

  assign in_accept    = in_valid_i & in_ready_o;
  assign idx_in_range = ({1'b0, idx_q} < dlwp_pkg::NodeCountW'(MAX_NODES));

  assign last_virt = node_count_q - dlwp_pkg::NodeCountW'(1);
  assign len_zero  = (node_index_i == '0) || ({1'b0, node_index_i} == last_virt) ||
                     (node_end_i < node_start_i);
  assign len_d     = len_zero ? '0
                   : ({1'b0, node_end_i} - {1'b0, node_start_i} + (SW+1)'(1));

  assign sum_w    = {1'b0, len_q} + {2'b00, best_q};
  assign sum_sat  = (sum_w > {2'b00, dlwp_pkg::ScoreMax});
  assign sum_clip = sum_sat ? dlwp_pkg::ScoreMax : sum_w[SW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dlwp_pkg::StIdle: begin
        if (in_accept) begin
          state_d = first_node_i ? dlwp_pkg::StSum : dlwp_pkg::StScan;
        end
      end
      dlwp_pkg::StScan: begin
        if (cnt_q == LastEntry) begin
          state_d = dlwp_pkg::StDrain;
        end
      end
      dlwp_pkg::StDrain: state_d = dlwp_pkg::StSum;
      dlwp_pkg::StSum: begin
        state_d = last_q ? dlwp_pkg::StFinish : dlwp_pkg::StIdle;
      end
      dlwp_pkg::StFinish: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = dlwp_pkg::StIdle;
        end
      end
      default: state_d = dlwp_pkg::StIdle;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    store_en   = 1'b0;
    unique case (state_q)
      dlwp_pkg::StIdle:   in_ready_o = 1'b1;
      dlwp_pkg::StSum:    store_en   = idx_in_range;
      dlwp_pkg::StFinish: out_load   = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dlwp_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= dlwp_pkg::NodeCountReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        dlwp_pkg::CfgNodeCount: node_count_q <= cfg_data_i;
        dlwp_pkg::CfgDirection: ;
        default: ;
      endcase
    end
  end

  // latch the accepted word
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      idx_q  <= node_index_i;
      mask_q <= neighbour_mask_i[MAX_NODES-1:0];
      last_q <= last_node_i;
      len_q  <= len_d;
    end
  end

  // store: registered read at the scan address, write of the node's score
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[cnt_q];
    if (store_en) begin
      mem_q[idx_q[AW-1:0]] <= sum_clip;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      sat_seen_q <= 1'b0;
    end else begin
      if (in_accept && first_node_i) begin
        // run start: clear the store and the clip flag
        valid_q    <= '0;
        sat_seen_q <= 1'b0;
      end else if (state_q == dlwp_pkg::StSum) begin
        if (sum_sat) begin
          sat_seen_q <= 1'b1;
        end
        if (store_en) begin
          valid_q[idx_q[AW-1:0]] <= 1'b1;
        end
      end
    end
  end

  // scan: issue one address per cycle, compare the entry read at the previous address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      cmp_vld_q <= 1'b0;
      best_q    <= '0;
    end else begin
      if (in_accept) begin
        cnt_q     <= '0;
        cmp_vld_q <= 1'b0;
        best_q    <= '0;
      end else if (state_q == dlwp_pkg::StScan || state_q == dlwp_pkg::StDrain) begin
        cmp_vld_q <= (state_q == dlwp_pkg::StScan) && mask_q[cnt_q] && valid_q[cnt_q];
        if (state_q == dlwp_pkg::StScan && cnt_q != LastEntry) begin
          cnt_q <= cnt_q + AW'(1);
        end
        if (cmp_vld_q && (rd_data_q > best_q)) begin
          best_q <= rd_data_q;
        end
      end
    end
  end

  // output register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // register each word's clipped sum; the output register takes it for a last word
  always_ff @(posedge clk_i) begin
    if (state_q == dlwp_pkg::StSum) begin
      out_len_q <= sum_clip;
    end
    if (out_load) begin
      out_sat_q <= sat_seen_q;
    end
  end

  logic [SW-1:0] path_len_q;
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      path_len_q <= out_len_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign path_length_o = path_len_q;
  assign saturated_o   = out_sat_q;

endmodule
`default_nettype wire

>>> rtl/dlwp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlwp_checker
// Port-level checks for the longest weighted path unit.
// ----------------------------------------------------------------------------
module dlwp_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_ready_i,
  input wire logic [dlwp_pkg::ScoreW-1:0] path_length_o,
  input wire logic                        saturated_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(path_length_o) &&
    $stable(saturated_o))
    else $error("result word changed while stalled");

  // one word at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while a word is in work");

  // a result appears only at the end of a word's work
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result word without a word in work");

endmodule

bind dag_longest_weighted_path_unit dlwp_checker u_dlwp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .path_length_o (path_length_o),
  .saturated_o   (saturated_o)
);
`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the longest weighted path unit. It scores every
// accepted node word with its own copy of the score store and compares each
// emitted path word field by field. A directed table comes first. Random
// phases follow, one per register setting, mostly walking well-formed runs.
// ----------------------------------------------------------------------------
module tb;
  import dlwp_pkg::*;

  localparam int unsigned MaxNodes     = 64;
  localparam int unsigned SettleCycles = MaxNodes + 16;  // one scan plus margin
  localparam int unsigned HoldCycles   = 1500;
  localparam int unsigned CycleLimit   = 1000000;

  // indexes past the register list; writes there must be dropped
  localparam logic [CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 2'd3;

  typedef struct packed {
    logic [NodeIdxW-1:0] index;
    logic [ScoreW-1:0]   start_pos;
    logic [ScoreW-1:0]   end_pos;
    logic [MaskW-1:0]    mask;
    logic                first;
    logic                last;
  } node_word_t;

  typedef struct packed {
    logic [ScoreW-1:0] path_length;
    logic              saturated;
  } path_word_t;

  // a directed row; typed_in marks a path word written out by hand
  typedef struct packed {
    node_word_t word;
    logic       typed_in;
    path_word_t want;
  } directed_row_t;

  typedef struct packed {
    logic [NodeCountW-1:0] node_count;
    logic                  backward;
    int                    words;
    logic                  calm;    // no idling on either side
    logic                  hold;    // receiver holds off for a long stretch
    logic                  pause;   // sender drains halfway through
  } phase_plan_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CfgIdxW-1:0]    cfg_index = '0;
  logic [CfgDataW-1:0]   cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [NodeIdxW-1:0]   node_index = '0;
  logic [ScoreW-1:0]     node_start = '0;
  logic [ScoreW-1:0]     node_end = '0;
  logic [MaskW-1:0]      neighbour_mask = '0;
  logic                  first_node = 1'b0;
  logic                  last_node = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [ScoreW-1:0]     path_length;
  logic                  saturated;

  // shadow of the block: register copies, score store and overflow flag
  logic [NodeCountW-1:0] shadow_node_count = NodeCountReset;
  logic                  shadow_backward = 1'b0;
  logic [ScoreW-1:0]     score_store [MaxNodes];
  logic                  overflow_seen = 1'b0;

  path_word_t            pending_paths [$];
  node_word_t            run_words [$];
  int                    mismatches = 0;
  int                    hold_requests = 0;
  int                    cycle_count = 0;
  logic                  tx_calm = 1'b0;
  logic                  rx_calm = 1'b0;

  dag_longest_weighted_path_unit dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .node_index_i     (node_index),
    .node_start_i     (node_start),
    .node_end_i       (node_end),
    .neighbour_mask_i (neighbour_mask),
    .first_node_i     (first_node),
    .last_node_i      (last_node),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .path_length_o    (path_length),
    .saturated_o      (saturated)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Score one node word against the shadow store; return 1 when it emits.
  function automatic logic score_node(input node_word_t w, output path_word_t p);
    logic [ScoreW-1:0]     best;
    logic [ScoreW:0]       span;
    logic [ScoreW+1:0]     total;
    logic [NodeCountW-1:0] sink_index;
    sink_index = shadow_node_count - 7'd1;
    best = '0;
    if (w.first) begin
      // a run start wipes the store and the flag, and ignores its mask
      for (int j = 0; j < MaxNodes; j++) score_store[j] = '0;
      overflow_seen = 1'b0;
    end else begin
      for (int j = 0; j < MaxNodes; j++)
        if (w.mask[j] && score_store[j] > best) best = score_store[j];
    end
    // virtual end nodes and inverted spans add nothing
    if (w.index == '0 || {1'b0, w.index} == sink_index || w.end_pos < w.start_pos)
      span = '0;
    else
      span = {1'b0, w.end_pos} - {1'b0, w.start_pos} + 1'b1;
    total = {1'b0, span} + {2'b00, best};
    if (total > {2'b00, ScoreMax}) begin
      total = {2'b00, ScoreMax};
      overflow_seen = 1'b1;
    end
    score_store[w.index] = total[ScoreW-1:0];
    p.path_length = total[ScoreW-1:0];
    p.saturated   = overflow_seen;
    return w.last;
  endfunction

  // Random node word: span shaped toward the corners, mask mostly limited to the
  // neighbours that a run in the given direction may point at.
  function automatic node_word_t shaped_word(input int idx, input logic backward);
    node_word_t        w;
    logic [MaskW-1:0]  reach;
    logic [ScoreW:0]   stretch;
    int                pick;
    pick = $urandom_range(0, 99);
    w.index = idx[NodeIdxW-1:0];
    w.start_pos = ScoreW'($urandom());
    if (pick < 70) begin
      stretch = {1'b0, w.start_pos} + (ScoreW+1)'($urandom_range(0, 2000));
      w.end_pos = stretch[ScoreW] ? ScoreMax : stretch[ScoreW-1:0];
    end else if (pick < 80) begin
      w.end_pos = w.start_pos >> $urandom_range(1, 8);
    end else if (pick < 90) begin
      w.start_pos = ScoreW'($urandom_range(0, 1000));
      w.end_pos = ScoreMax - ScoreW'($urandom_range(0, 1000));
    end else begin
      w.end_pos = ScoreW'($urandom());
    end
    if (backward) reach = ~((64'd1 << (idx + 1)) - 64'd1);
    else          reach = (64'd1 << idx) - 64'd1;
    w.mask = {$urandom(), $urandom()};
    if ($urandom_range(0, 9) != 0) w.mask = w.mask & reach;
    w.first = 1'b0;
    w.last = 1'b0;
    return w;
  endfunction

  // Queue one run: start node, a random ordered subset of inner nodes and,
  // most of the time, the closing node that emits the path word.
  task automatic append_run(input logic [NodeCountW-1:0] count, input logic backward);
    logic [NodeCountW-1:0] sink_index;
    node_word_t            w;
    int                    top;
    int                    keep_pct;
    sink_index = count - 7'd1;
    top = (sink_index > 7'd63) ? 63 : int'(sink_index);
    keep_pct = $urandom_range(3, 30);
    w = shaped_word(backward ? top : 0, backward);
    w.mask = {$urandom(), $urandom()};
    w.first = 1'b1;
    w.last = (top == 0);
    run_words.push_back(w);
    if (top == 0) return;
    for (int i = 1; i < top; i++)
      if ($urandom_range(0, 99) < keep_pct)
        run_words.push_back(shaped_word(backward ? top - i : i, backward));
    // drop the closing node now and then: a broken run
    if ($urandom_range(0, 99) >= 8) begin
      w = shaped_word(backward ? 0 : top, backward);
      w.last = 1'b1;
      run_words.push_back(w);
    end
  endtask

  // Offer one word, idling first at random; returns at the accepting edge.
  task automatic offer_word(input node_word_t w, input logic typed_in,
                            input path_word_t want);
    path_word_t p;
    while (!tx_calm && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    node_index     <= w.index;
    node_start     <= w.start_pos;
    node_end       <= w.end_pos;
    neighbour_mask <= w.mask;
    first_node     <= w.first;
    last_node      <= w.last;
    do @(posedge clk); while (!in_ready);
    if (score_node(w, p)) pending_paths.push_back(typed_in ? want : p);
  endtask

  // Drop valid and wait for every path word, then idle for the given extra margin.
  task automatic drain_results(input int extra);
    in_valid <= 1'b0;
    while (pending_paths.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (idx == CfgNodeCount) shadow_node_count = data;
    else if (idx == CfgDirection) shadow_backward = data[0];
  endtask

  // Directed rows at the reset setting (64 nodes, forward).
  directed_row_t directed_rows [14] = '{
    // store still at reset, no run start yet
    '{'{6'd5,  31'd10, 31'd19, '1, 1'b0, 1'b1}, 1'b1, '{31'd10, 1'b0}},
    // virtual source opens a run
    '{'{6'd0,  31'd100, 31'd200, '1, 1'b1, 1'b0}, 1'b0, '0},
    '{'{6'd1,  31'd0, 31'd0, 64'h1, 1'b0, 1'b0}, 1'b0, '0},
    // end below start
    '{'{6'd2,  31'd5, 31'd4, 64'h3, 1'b0, 1'b1}, 1'b0, '0},
    // widest span overflows on its own
    '{'{6'd3,  31'd0, ScoreMax, 64'h0, 1'b0, 1'b1}, 1'b1, '{ScoreMax, 1'b1}},
    '{'{6'd4,  ScoreMax, ScoreMax, 64'h8, 1'b0, 1'b1}, 1'b1, '{ScoreMax, 1'b1}},
    // virtual sink, flag still set from the overflow
    '{'{6'd63, 31'd0, 31'd0, '1, 1'b0, 1'b1}, 1'b1, '{ScoreMax, 1'b1}},
    // run start and end in one word
    '{'{6'd7,  31'd1000, 31'd1999, '1, 1'b1, 1'b1}, 1'b1, '{31'd1000, 1'b0}},
    // unvisited neighbour reads zero
    '{'{6'd9,  31'd0, 31'd0, (64'd1 << 40) | (64'd1 << 7), 1'b0, 1'b1}, 1'b0, '0},
    '{'{6'd10, 31'd3, 31'd3, 64'h8000_0000_0000_0000, 1'b0, 1'b0}, 1'b0, '0},
    '{'{6'd11, 31'h2AAA_AAAA, 31'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b1},
      1'b0, '0},
    '{'{6'd12, 31'h5555_5555, 31'h2AAA_AAAA, 64'h5555_5555_5555_5555, 1'b0, 1'b1},
      1'b0, '0},
    '{'{6'd62, 31'h7FFF_FF00, ScoreMax, '1, 1'b0, 1'b1}, 1'b0, '0},
    // virtual source as a one-word run
    '{'{6'd0,  ScoreMax, 31'd0, '1, 1'b1, 1'b1}, 1'b1, '{31'd0, 1'b0}}
  };

  // One phase per setting; the out-of-range node counts leave only node 0
  // virtual (0, 100, 127) or make the source the sink as well (1).
  phase_plan_t phase_plans [8] = '{
    '{7'd64,  1'b1, 300, 1'b0, 1'b0, 1'b0},
    '{7'd2,   1'b0, 150, 1'b1, 1'b0, 1'b0},
    '{7'd37,  1'b1, 300, 1'b0, 1'b1, 1'b0},
    '{7'd0,   1'b0, 200, 1'b0, 1'b0, 1'b0},
    '{7'd100, 1'b1, 200, 1'b0, 1'b0, 1'b0},
    '{7'd1,   1'b0, 100, 1'b0, 1'b0, 1'b0},
    '{7'd127, 1'b0, 100, 1'b0, 1'b0, 1'b0},
    '{7'd64,  1'b0, 500, 1'b0, 1'b0, 1'b1}
  };

  // Result side: check each accepted path word, then pick the next ready.
  initial begin : result_side
    path_word_t want;
    int         hold_left;
    int         holds_seen;
    hold_left = 0;
    holds_seen = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (pending_paths.size() == 0) begin
          $error("unexpected path word: path_length %0d saturated %0b",
                 path_length, saturated);
          mismatches++;
        end else begin
          want = pending_paths.pop_front();
          if (path_length !== want.path_length) begin
            $error("path_length: expected %0d, got %0d", want.path_length, path_length);
            mismatches++;
          end
          if (saturated !== want.saturated) begin
            $error("saturated: expected %0b, got %0b", want.saturated, saturated);
            mismatches++;
          end
        end
      end
      // a new hold request starts a long stall counted here
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= rx_calm || ($urandom_range(0, 99) >= 25);
      end
    end
  end

  // Watchdog: give up well past the slowest legal run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    node_word_t w;
    for (int j = 0; j < MaxNodes; j++) score_store[j] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table at the reset setting
    foreach (directed_rows[r])
      offer_word(directed_rows[r].word, directed_rows[r].typed_in, directed_rows[r].want);

    foreach (phase_plans[ph]) begin
      // registers move only with the block idle
      drain_results(SettleCycles);
      write_reg(CfgNodeCount, phase_plans[ph].node_count);
      // upper data bits must not leak into the direction bit
      write_reg(CfgDirection, {(CfgDataW-1)'($urandom()), phase_plans[ph].backward});
      if (ph == 0) begin
        write_reg(CfgSpareA, 7'h55);
        write_reg(CfgSpareB, 7'h2A);
      end
      cfg_we <= 1'b0;
      @(posedge clk);

      tx_calm = phase_plans[ph].calm;
      rx_calm = phase_plans[ph].calm;
      // stall the receiver while the sender keeps pushing, so the block backs up
      if (phase_plans[ph].hold) begin
        tx_calm = 1'b1;
        hold_requests++;
      end

      run_words.delete();
      while (run_words.size() < phase_plans[ph].words) begin
        if ($urandom_range(0, 99) < 80) begin
          append_run(phase_plans[ph].node_count, phase_plans[ph].backward);
        end else begin
          // noise: any index, any mask, run markers at random
          w = shaped_word($urandom_range(0, 63), 1'($urandom()));
          w.mask = {$urandom(), $urandom()};
          w.first = ($urandom_range(0, 99) < 15);
          w.last = ($urandom_range(0, 99) < 30);
          run_words.push_back(w);
        end
      end

      foreach (run_words[i]) begin
        if (phase_plans[ph].pause && i == run_words.size() / 2)
          drain_results(0);
        if (phase_plans[ph].hold && i == 40)
          tx_calm = phase_plans[ph].calm;
        offer_word(run_words[i], 1'b0, '0);
      end
    end

    drain_results(SettleCycles);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
